>>> hdl/bfiq_pkg.sv
// Shared constants, codes and types for the Bloom filter insert/query core.
package bfiq_pkg;

	localparam int SLICE_W         = 64;
	localparam int SLICE_COUNT     = 7;
	localparam int SLICE_IDX_W     = 3;
	localparam int SLICE_CNT_W     = 6;
	localparam int BIT_COUNT_W     = 17;
	localparam int BIT_COUNT_RESET = 65536;
	localparam int ROW_W           = 32;
	localparam int ROW_SEL_W       = 5;
	localparam int MAX_BITS_DEF    = 65536;
	localparam int HASH_COUNT_DEF  = 7;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_READ,
		ST_UPDATE
	} bfiq_state_t;

	typedef struct packed {
		logic rd;
		logic wr;
	} bfiq_store_cmd_t;

endpackage

>>> hdl/bfiq_div.sv
// Bit-serial remainder unit: 64-bit dividend modulo a narrow divisor.
module bfiq_div #(
	parameter int MOD_W = 17
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  logic [bfiq_pkg::SLICE_W-1:0] dividend,
	input  logic [MOD_W-1:0]            divisor,
	output logic                        done,
	output logic [MOD_W-1:0]            rem
);

	logic [bfiq_pkg::SLICE_W-1:0]     dvd_q;
	logic [MOD_W-1:0]                 rem_q;
	logic [bfiq_pkg::SLICE_CNT_W-1:0] cnt_q;
	logic                             run_q;
	logic                             done_q;
	logic [MOD_W:0]                   trial;
	logic [MOD_W:0]                   diff;
	logic [MOD_W-1:0]                 rem_next;

	// One restoring step: shift in the next dividend bit, subtract if it fits.
	always_comb begin
		trial    = {rem_q, dvd_q[bfiq_pkg::SLICE_W-1]};
		diff     = trial - {1'b0, divisor};
		rem_next = (trial >= {1'b0, divisor}) ? diff[MOD_W-1:0] : trial[MOD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == '1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[bfiq_pkg::SLICE_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rem < divisor))
		else $error("remainder not below divisor");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	a_load_runs: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (run_q && !done))
		else $error("load did not start a run");

endmodule

>>> hdl/bfiq_store.sv
// Filter bit store: rows of flags with a clearing pass after reset.
module bfiq_store #(
	parameter int ROWS   = 2048,
	parameter int ADDR_W = 11
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bfiq_pkg::bfiq_store_cmd_t    cmd,
	input  logic [ADDR_W-1:0]            addr,
	input  logic [bfiq_pkg::ROW_W-1:0]   wr_data,
	output logic [bfiq_pkg::ROW_W-1:0]   rd_data,
	output logic                         clearing
);

	logic [bfiq_pkg::ROW_W-1:0] mem [ROWS];
	logic [bfiq_pkg::ROW_W-1:0] rd_data_q;
	logic                       clr_q;
	logic [ADDR_W-1:0]          clr_row_q;

	// Sweep every row to zero, one row a cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_row_q <= '0;
		end else if (clr_q) begin
			if (clr_row_q == ADDR_W'(ROWS - 1)) begin
				clr_q <= 1'b0;
			end else begin
				clr_row_q <= clr_row_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_row_q] <= '0;
		end else if (cmd.wr) begin
			mem[addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_data_q <= mem[addr];
		end
	end

	assign rd_data  = rd_data_q;
	assign clearing = clr_q;

endmodule

>>> hdl/bloom_filter_insert_query_core.sv
// Bloom filter insert/query core: sequencer, remainder unit and bit store.
//
// Each item carries an operation (op: 0 insert, 1 query) and seven 64-bit
// slices of an already hashed key. Every slice in use is reduced modulo the
// active bit count (bit_count, with zero taken as one and values above
// MAX_BITS taken as MAX_BITS) and names one flag of the store. An insert sets
// the named flags; a query reports hit = 1 only when all of them are set.
// Hand an item over by raising start while busy is low. Exactly one result
// comes back per item: done is high for one cycle with hit valid in that same
// cycle, and the receiver must take it then, since nothing can hold it off.
// Busy stays high while each slice in use is handled in turn by the shared
// bit-serial remainder unit, which retires one dividend bit a cycle: a load
// step, the division, a step in which the unit reports done, then a read and
// an update of the store row. done rises in the cycle busy falls, and start
// may be raised again in that cycle. After reset the store runs a clearing
// pass of one row a cycle, with busy high until the cycle after the pass
// ends; bit_count writes are taken at any time and should only be made while
// no item is in flight. Changing bit_count leaves the store as it is.
module bloom_filter_insert_query_core #(
	parameter int MAX_BITS   = bfiq_pkg::MAX_BITS_DEF,
	parameter int HASH_COUNT = bfiq_pkg::HASH_COUNT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                bit_count_we,
	input  logic [bfiq_pkg::BIT_COUNT_W-1:0]    bit_count,
	input  logic                                start,
	output logic                                busy,
	input  logic                                op,
	input  logic [bfiq_pkg::SLICE_W-1:0]        slice_0,
	input  logic [bfiq_pkg::SLICE_W-1:0]        slice_1,
	input  logic [bfiq_pkg::SLICE_W-1:0]        slice_2,
	input  logic [bfiq_pkg::SLICE_W-1:0]        slice_3,
	input  logic [bfiq_pkg::SLICE_W-1:0]        slice_4,
	input  logic [bfiq_pkg::SLICE_W-1:0]        slice_5,
	input  logic [bfiq_pkg::SLICE_W-1:0]        slice_6,
	output logic                                done,
	output logic                                hit
);

	// Sizes that follow from the store depth.
	localparam int MOD_W  = $clog2(MAX_BITS + 1);
	localparam int IDX_W  = $clog2(MAX_BITS);
	localparam int ROWS   = (MAX_BITS + bfiq_pkg::ROW_W - 1) / bfiq_pkg::ROW_W;
	localparam int ADDR_W = IDX_W - bfiq_pkg::ROW_SEL_W;
	localparam int N_USED = (HASH_COUNT > bfiq_pkg::SLICE_COUNT) ?
		bfiq_pkg::SLICE_COUNT : HASH_COUNT;

	bfiq_pkg::bfiq_state_t        state_q, state_d;
	logic [bfiq_pkg::BIT_COUNT_W-1:0] bit_count_q;
	logic [bfiq_pkg::SLICE_W-1:0] slice_q [bfiq_pkg::SLICE_COUNT];
	logic [bfiq_pkg::SLICE_IDX_W-1:0] sl_q;
	logic                         op_q;
	logic                         all_set_q;
	logic [MOD_W-1:0]             mod_q;
	logic                         done_q;
	logic                         hit_q;

	logic [31:0]                  bc_ext;
	logic [31:0]                  mod_full;
	logic                         div_load;
	logic                         div_done;
	logic [MOD_W-1:0]             div_rem;
	logic [IDX_W-1:0]             bit_idx;
	logic [ADDR_W-1:0]            row_addr;
	logic [bfiq_pkg::ROW_SEL_W-1:0] bit_sel;
	logic [bfiq_pkg::ROW_W-1:0]   row_rd;
	logic [bfiq_pkg::ROW_W-1:0]   row_wr;
	logic                         flag;
	logic                         last_slice;
	logic                         clearing;
	bfiq_pkg::bfiq_store_cmd_t    store_cmd;

	// Clamp the configured count into the legal modulus range.
	always_comb begin
		bc_ext = {{(32 - bfiq_pkg::BIT_COUNT_W){1'b0}}, bit_count_q};
		if (bc_ext == 32'd0) begin
			mod_full = 32'd1;
		end else if (bc_ext > 32'(MAX_BITS)) begin
			mod_full = 32'(MAX_BITS);
		end else begin
			mod_full = bc_ext;
		end
	end

	// The remainder stays put from the end of a division until the next load.
	assign bit_idx    = div_rem[IDX_W-1:0];
	assign row_addr   = bit_idx[IDX_W-1:bfiq_pkg::ROW_SEL_W];
	assign bit_sel    = bit_idx[bfiq_pkg::ROW_SEL_W-1:0];
	assign flag       = row_rd[bit_sel];
	assign row_wr     = row_rd | (bfiq_pkg::ROW_W'(1) << bit_sel);
	assign last_slice = (sl_q == bfiq_pkg::SLICE_IDX_W'(N_USED - 1));

	// Sequencer: load a slice, divide, read its row, then check or set the flag.
	always_comb begin
		state_d      = state_q;
		div_load     = 1'b0;
		store_cmd.rd = 1'b0;
		store_cmd.wr = 1'b0;
		unique case (state_q)
			bfiq_pkg::ST_CLEAR: begin
				if (!clearing) begin
					state_d = bfiq_pkg::ST_IDLE;
				end
			end
			bfiq_pkg::ST_IDLE: begin
				if (start) begin
					state_d = bfiq_pkg::ST_LOAD;
				end
			end
			bfiq_pkg::ST_LOAD: begin
				div_load = 1'b1;
				state_d  = bfiq_pkg::ST_DIV;
			end
			bfiq_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = bfiq_pkg::ST_READ;
				end
			end
			bfiq_pkg::ST_READ: begin
				store_cmd.rd = 1'b1;
				state_d      = bfiq_pkg::ST_UPDATE;
			end
			bfiq_pkg::ST_UPDATE: begin
				store_cmd.wr = (op_q == bfiq_pkg::OP_INSERT);
				state_d      = last_slice ? bfiq_pkg::ST_IDLE : bfiq_pkg::ST_LOAD;
			end
			default: begin
				state_d = bfiq_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfiq_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_count_q <= bfiq_pkg::BIT_COUNT_W'(bfiq_pkg::BIT_COUNT_RESET);
		end else if (bit_count_we) begin
			bit_count_q <= bit_count;
		end
	end

	// Result strobe: raise for one cycle at the end of the last slice.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			hit_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			hit_q  <= 1'b0;
			if (state_q == bfiq_pkg::ST_UPDATE && last_slice) begin
				done_q <= 1'b1;
				hit_q  <= (op_q == bfiq_pkg::OP_QUERY) && all_set_q && flag;
			end
		end
	end

	// Item payload and per-item working registers.
	always_ff @(posedge clk) begin
		if (state_q == bfiq_pkg::ST_IDLE && start) begin
			op_q       <= op;
			mod_q      <= mod_full[MOD_W-1:0];
			sl_q       <= '0;
			all_set_q  <= 1'b1;
			slice_q[0] <= slice_0;
			slice_q[1] <= slice_1;
			slice_q[2] <= slice_2;
			slice_q[3] <= slice_3;
			slice_q[4] <= slice_4;
			slice_q[5] <= slice_5;
			slice_q[6] <= slice_6;
		end else if (state_q == bfiq_pkg::ST_UPDATE) begin
			all_set_q <= all_set_q & flag;
			sl_q      <= sl_q + 1'b1;
		end
	end

	bfiq_div #(
		.MOD_W(MOD_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (div_load),
		.dividend(slice_q[sl_q]),
		.divisor (mod_q),
		.done    (div_done),
		.rem     (div_rem)
	);

	bfiq_store #(
		.ROWS  (ROWS),
		.ADDR_W(ADDR_W)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (store_cmd),
		.addr    (row_addr),
		.wr_data (row_wr),
		.rd_data (row_rd),
		.clearing(clearing)
	);

	assign busy = (state_q != bfiq_pkg::ST_IDLE);
	assign done = done_q;
	assign hit  = hit_q;

	a_done_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == bfiq_pkg::ST_UPDATE))
		else $error("result strobe without a finished update");

	a_insert_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && op_q == bfiq_pkg::OP_INSERT) |-> !hit)
		else $error("insert reported a hit");

	a_no_store_write_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> (state_q == bfiq_pkg::ST_CLEAR && !store_cmd.wr && !store_cmd.rd))
		else $error("store access during clearing pass");

	a_accept_starts_load: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == bfiq_pkg::ST_LOAD))
		else $error("accepted item did not start a slice");

endmodule
